>>> rtl/jsu_pkg.sv
// shared types, status codes and utf-8 byte helpers for the json string unescape unit
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    localparam logic [2:0] ST_RUNNING      = 3'd0;
    localparam logic [2:0] ST_DONE         = 3'd1;
    localparam logic [2:0] ST_UNTERMINATED = 3'd2;
    localparam logic [2:0] ST_BAD_ESCAPE   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_ESC  = 3'd4;
    localparam logic [2:0] ST_BAD_UNICODE  = 3'd5;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // one queued job: an optional lone high surrogate, then the main sequence
    typedef struct packed {
        logic        pre_en;
        logic [15:0] pre_code;
        logic [2:0]  main_cnt;
        logic [20:0] main_val;
        logic [2:0]  status;
    } jsu_job_t;

    // byte q of the utf-8 sequence of length cnt carrying v
    function automatic logic [7:0] utf8_byte(input logic [20:0] v, input logic [2:0] cnt,
                                             input logic [2:0] q);
        logic [7:0] r;
        r = UTF8_CONT | {2'b00, v[5:0]};
        case (cnt)
            3'd1: r = v[7:0];
            3'd2:
            begin
                if (q == 3'd0) r = UTF8_LEAD2 | {3'b000, v[10:6]};
            end
            3'd3:
            begin
                if (q == 3'd0) r = UTF8_LEAD3 | {4'b0000, v[15:12]};
                else if (q == 3'd1) r = UTF8_CONT | {2'b00, v[11:6]};
            end
            3'd4:
            begin
                if (q == 3'd0) r = UTF8_LEAD4 | {5'b00000, v[20:18]};
                else if (q == 3'd1) r = UTF8_CONT | {2'b00, v[17:12]};
                else if (q == 3'd2) r = UTF8_CONT | {2'b00, v[11:6]};
            end
            default: r = UTF8_CONT | {2'b00, v[5:0]};
        endcase
        return r;
    endfunction

endpackage

>>> rtl/jsu_in_if.sv
// input channel: one raw text byte per word
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source(output valid, text_byte, end_of_text, input ready);
    modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

>>> rtl/jsu_out_if.sv
// output channel: one decoded result per word
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] status;
    logic       last;

    modport source(output valid, out_byte, has_byte, status, last, input ready);
    modport sink(input valid, out_byte, has_byte, status, last, output ready);
endinterface

>>> rtl/jsu_front.sv
// front end: escape state machine, turns a text byte into a queued job when it yields output or a status
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     text,
    input  logic       q_full,
    output logic       push,
    output jsu_job_t   job
);

    localparam logic [3:0] PH_BODY    = 4'd0;
    localparam logic [3:0] PH_ESC     = 4'd1;
    localparam logic [3:0] PH_HEX     = 4'd2;
    localparam logic [3:0] PH_HIGH    = 4'd3;
    localparam logic [3:0] PH_HIGH_BS = 4'd4;
    localparam logic [3:0] PH_LOW_HEX = 4'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic        hex_prefix_ok_reg, hex_prefix_ok_next;
    logic [15:0] pending_high_reg, pending_high_next;

    logic        accept;
    logic [7:0]  b;
    logic        hd_ok;
    logic [3:0]  hd_val;
    logic [15:0] tk_value;
    logic        tk_prefix;
    logic        tk_done;
    logic        body_b;
    logic        esc_b;
    logic        fin;
    logic [15:0] fin_code;
    logic        pre_en;
    logic [2:0]  main_cnt;
    logic [20:0] main_val;
    logic [2:0]  st;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign b          = text.text_byte;

    always_comb
    begin
        hd_ok  = 1'b1;
        hd_val = 4'd0;
        if (b inside {[8'h30:8'h39]}) hd_val = b[3:0];
        else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) hd_val = b[3:0] + 4'd9;
        else hd_ok = 1'b0;
    end

    assign tk_prefix = hex_prefix_ok_reg && hd_ok;
    assign tk_value  = tk_prefix ? {hex_value_reg[11:0], hd_val} : hex_value_reg;
    assign tk_done   = (hex_count_reg == 3'd3);

    always_comb
    begin
        phase_next         = phase_reg;
        hex_value_next     = hex_value_reg;
        hex_count_next     = hex_count_reg;
        hex_prefix_ok_next = hex_prefix_ok_reg;
        pending_high_next  = pending_high_reg;
        body_b   = 1'b0;
        esc_b    = 1'b0;
        fin      = 1'b0;
        fin_code = tk_value;
        pre_en   = 1'b0;
        main_cnt = 3'd0;
        main_val = 21'd0;
        st       = ST_RUNNING;

        case (phase_reg)
            PH_BODY: body_b = 1'b1;
            PH_ESC:  esc_b = 1'b1;
            PH_HEX:
            begin
                hex_value_next     = tk_value;
                hex_prefix_ok_next = tk_prefix;
                hex_count_next     = hex_count_reg + 3'd1;
                fin                = tk_done;
            end
            PH_HIGH:
            begin
                if (b == CH_BSLASH) phase_next = PH_HIGH_BS;
                else
                begin
                    pre_en     = 1'b1;
                    phase_next = PH_BODY;
                    body_b     = 1'b1;
                end
            end
            PH_HIGH_BS:
            begin
                if (b == CH_U)
                begin
                    phase_next         = PH_LOW_HEX;
                    hex_value_next     = 16'd0;
                    hex_count_next     = 3'd0;
                    hex_prefix_ok_next = 1'b1;
                end
                else
                begin
                    pre_en = 1'b1;
                    esc_b  = 1'b1;
                end
            end
            PH_LOW_HEX:
            begin
                hex_value_next     = tk_value;
                hex_prefix_ok_next = tk_prefix;
                hex_count_next     = hex_count_reg + 3'd1;
                if (tk_done)
                begin
                    if (tk_value inside {[16'hDC00:16'hDFFF]})
                    begin
                        // surrogate pair folds into one 4-byte sequence
                        main_cnt   = 3'd4;
                        main_val   = {1'b0, pending_high_reg[9:0], tk_value[9:0]} + 21'h10000;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        pre_en = 1'b1;
                        fin    = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_BODY;
                body_b     = 1'b1;
            end
        endcase

        if (body_b)
        begin
            if (b == CH_QUOTE) st = ST_DONE;
            else if (b == CH_BSLASH) phase_next = PH_ESC;
            else
            begin
                main_cnt = 3'd1;
                main_val = {13'd0, b};
            end
        end

        if (esc_b)
        begin
            phase_next = PH_BODY;
            main_cnt   = 3'd1;
            case (b)
                CH_QUOTE:  main_val = {13'd0, CH_QUOTE};
                CH_BSLASH: main_val = {13'd0, CH_BSLASH};
                CH_SLASH:  main_val = {13'd0, CH_SLASH};
                CH_B:      main_val = 21'h08;
                CH_F:      main_val = 21'h0C;
                CH_N:      main_val = 21'h0A;
                CH_R:      main_val = 21'h0D;
                CH_T:      main_val = 21'h09;
                CH_U:
                begin
                    main_cnt           = 3'd0;
                    phase_next         = PH_HEX;
                    hex_value_next     = 16'd0;
                    hex_count_next     = 3'd0;
                    hex_prefix_ok_next = 1'b1;
                end
                default:
                begin
                    main_cnt = 3'd0;
                    st       = ST_UNKNOWN_ESC;
                end
            endcase
        end

        if (fin)
        begin
            if (fin_code inside {[16'hD800:16'hDBFF]})
            begin
                pending_high_next = fin_code;
                phase_next        = PH_HIGH;
            end
            else
            begin
                main_val   = {5'd0, fin_code};
                phase_next = PH_BODY;
                if (fin_code < 16'h0080) main_cnt = 3'd1;
                else if (fin_code < 16'h0800) main_cnt = 3'd2;
                else main_cnt = 3'd3;
            end
        end

        // end of text inside the string sets an error status; a waiting high surrogate goes out alone
        if (st == ST_RUNNING && text.end_of_text)
        begin
            case (phase_next)
                PH_ESC: st = ST_BAD_ESCAPE;
                PH_HEX: st = ST_BAD_UNICODE;
                PH_HIGH, PH_HIGH_BS, PH_LOW_HEX:
                begin
                    main_cnt = 3'd3;
                    main_val = {5'd0, pending_high_next};
                    if (phase_next == PH_HIGH) st = ST_UNTERMINATED;
                    else if (phase_next == PH_HIGH_BS) st = ST_BAD_ESCAPE;
                    else st = ST_BAD_UNICODE;
                end
                default: st = ST_UNTERMINATED;
            endcase
        end

        if (st != ST_RUNNING)
        begin
            phase_next         = PH_BODY;
            hex_value_next     = 16'd0;
            hex_count_next     = 3'd0;
            hex_prefix_ok_next = 1'b1;
            pending_high_next  = 16'd0;
        end
    end

    assign push          = accept && (pre_en || main_cnt != 3'd0 || st != ST_RUNNING);
    assign job.pre_en    = pre_en;
    assign job.pre_code  = pending_high_reg;
    assign job.main_cnt  = main_cnt;
    assign job.main_val  = main_val;
    assign job.status    = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_BODY;
            hex_value_reg     <= 16'd0;
            hex_count_reg     <= 3'd0;
            hex_prefix_ok_reg <= 1'b1;
            pending_high_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            hex_value_reg     <= hex_value_next;
            hex_count_reg     <= hex_count_next;
            hex_prefix_ok_reg <= hex_prefix_ok_next;
            pending_high_reg  <= pending_high_next;
        end
    end

endmodule

>>> rtl/jsu_queue.sv
// job queue between the front end and the byte emitter
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = JSU_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jsu_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output jsu_job_t head_job
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    jsu_job_t       mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CW'(1);
        else if (pop && !push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop) rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
    end

endmodule

>>> rtl/jsu_back.sv
// back end: expands each job into result words, one per cycle while the output is not stalled
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  jsu_job_t   head_job,
    output logic       pop,
    jsu_out_if.source  decoded
);

    logic [2:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       has_byte_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    logic [2:0] total;
    logic [2:0] last_idx;
    logic [2:0] q;
    logic       is_last;
    logic       has_byte;
    logic [7:0] byte_val;
    logic       load;

    assign total    = (head_job.pre_en ? 3'd3 : 3'd0) + head_job.main_cnt;
    assign last_idx = (total == 3'd0) ? 3'd0 : total - 3'd1;
    assign is_last  = (idx_reg == last_idx);
    assign has_byte = (total != 3'd0);
    assign q        = idx_reg - (head_job.pre_en ? 3'd3 : 3'd0);

    always_comb
    begin
        if (!has_byte) byte_val = 8'd0;
        else if (head_job.pre_en && idx_reg < 3'd3)
            byte_val = utf8_byte({5'd0, head_job.pre_code}, 3'd3, idx_reg);
        else byte_val = utf8_byte(head_job.main_val, head_job.main_cnt, q);
    end

    assign load = head_valid && (!out_valid_reg || decoded.ready);
    assign pop  = load && is_last;

    assign decoded.valid    = out_valid_reg;
    assign decoded.out_byte = out_byte_reg;
    assign decoded.has_byte = has_byte_reg;
    assign decoded.status   = status_reg;
    assign decoded.last     = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            has_byte_reg <= has_byte;
            status_reg   <= is_last ? head_job.status : ST_RUNNING;
            last_reg     <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (load) out_valid_reg <= 1'b1;
            else if (decoded.ready) out_valid_reg <= 1'b0;
            if (load) idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

endmodule

>>> rtl/json_string_unescape_utf8_unit.sv
// top level: json string body decoder to utf-8, front end, job queue, byte emitter
//
//  channel   dir   payload                              word
//  text      in    text_byte[7:0], end_of_text          one raw byte of the string body
//  decoded   out   out_byte[7:0], has_byte, status[2:0], last   one decoded result
//
// the front end takes one text byte per cycle while the job queue has room
// the emitter sends one result per cycle while the output is not stalled; a byte can decode
// to up to 6 results, and QUEUE_DEPTH jobs absorb those bursts
// a stalled output holds its word and the queue fills before text.ready drops
// rst_n clears the escape state, the queue and the output valid at once
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source decoded
);

    logic     q_full;
    logic     push;
    jsu_job_t push_job;
    logic     pop;
    logic     head_valid;
    jsu_job_t head_job;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .decoded    (decoded)
    );

`ifndef NO_ASSERTIONS
    // only the closing word of a job carries a status
    assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && !decoded.last |-> decoded.has_byte && decoded.status == ST_RUNNING)
    else $error("non-last word without byte or with status");

    // a word with no byte must be a status-only closing word
    assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && !decoded.has_byte |-> decoded.out_byte == 8'd0 &&
            decoded.status != ST_RUNNING)
    else $error("empty word without status");

    // the queue never takes a job when full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
    else $error("push into full queue");

    // a job is only popped while the queue holds one
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> tb/jsu_decode_checker.sv
// checker for the json string unescape unit: decodes the text words itself and compares results
module jsu_decode_checker
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jsu_in_if    text,
    jsu_out_if   decoded,
    output int   mismatches,
    output int   words_due,
    output int   words_in,
    output int   words_out,
    output int   closed_strings,
    output int   broken_strings
);

    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_CR  = 8'h0D;

    typedef enum logic [2:0] {
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_HIGH,
        SCAN_HIGH_BS,
        SCAN_LOW_HEX
    } scan_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [2:0] status;
        logic       last;
    } utf8_word_t;

    scan_t       scan;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic        hex_ok;
    logic [15:0] high_sur;

    logic [7:0]  utf8_bytes[$];
    logic [2:0]  end_status;
    utf8_word_t  due_words[$];

    int n_bad, n_in, n_out, n_closed, n_broken;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return {1'b1, c[3:0] + 4'd9};
        return 5'b0;
    endfunction

    task automatic clear_hex();
        hex_acc = 16'h0000;
        hex_cnt = 3'd0;
        hex_ok  = 1'b1;
    endtask

    task automatic reset_scan();
        scan = SCAN_BODY;
        clear_hex();
        high_sur = 16'h0000;
    endtask

    task automatic put_bmp(input logic [15:0] c);
        if (c < 16'h0080)
            utf8_bytes.push_back(c[7:0]);
        else if (c < 16'h0800)
        begin
            utf8_bytes.push_back({3'b110, c[10:6]});
            utf8_bytes.push_back({2'b10, c[5:0]});
        end
        else
        begin
            utf8_bytes.push_back({4'b1110, c[15:12]});
            utf8_bytes.push_back({2'b10, c[11:6]});
            utf8_bytes.push_back({2'b10, c[5:0]});
        end
    endtask

    // digits after the first non-hex byte still count but add nothing
    task automatic take_hex(input logic [7:0] c, output logic full);
        logic [4:0] nib;
        nib = hex_nibble(c);
        if (!nib[4])
            hex_ok = 1'b0;
        else if (hex_ok)
            hex_acc = {hex_acc[11:0], nib[3:0]};
        hex_cnt = hex_cnt + 3'd1;
        full = (hex_cnt >= 3'd4);
    endtask

    task automatic settle_code(input logic [15:0] c);
        if (c >= 16'hD800 && c <= 16'hDBFF)
        begin
            high_sur = c;
            scan = SCAN_HIGH;
        end
        else
        begin
            put_bmp(c);
            scan = SCAN_BODY;
        end
    endtask

    task automatic body_byte(input logic [7:0] c);
        if (c == "\"")
            end_status = ST_DONE;
        else if (c == "\\")
            scan = SCAN_ESC;
        else
            utf8_bytes.push_back(c);
    endtask

    task automatic esc_byte(input logic [7:0] c);
        scan = SCAN_BODY;
        case (c)
            "\"", "\\", "/": utf8_bytes.push_back(c);
            "b": utf8_bytes.push_back(CTRL_BS);
            "f": utf8_bytes.push_back(CTRL_FF);
            "n": utf8_bytes.push_back(CTRL_LF);
            "r": utf8_bytes.push_back(CTRL_CR);
            "t": utf8_bytes.push_back(CTRL_TAB);
            "u":
            begin
                scan = SCAN_HEX;
                clear_hex();
            end
            default: end_status = ST_UNKNOWN_ESC;
        endcase
    endtask

    task automatic decode_text_word(input logic [7:0] c, input logic eot);
        logic        full;
        logic [20:0] cp;
        utf8_word_t  w;
        utf8_bytes.delete();
        end_status = ST_RUNNING;
        case (scan)
            SCAN_BODY: body_byte(c);
            SCAN_ESC: esc_byte(c);
            SCAN_HEX:
            begin
                take_hex(c, full);
                if (full)
                    settle_code(hex_acc);
            end
            SCAN_HIGH:
            begin
                if (c == "\\")
                    scan = SCAN_HIGH_BS;
                else
                begin
                    put_bmp(high_sur);
                    scan = SCAN_BODY;
                    body_byte(c);
                end
            end
            SCAN_HIGH_BS:
            begin
                if (c == "u")
                begin
                    scan = SCAN_LOW_HEX;
                    clear_hex();
                end
                else
                begin
                    put_bmp(high_sur);
                    esc_byte(c);
                end
            end
            SCAN_LOW_HEX:
            begin
                take_hex(c, full);
                if (full)
                begin
                    if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF)
                    begin
                        // both surrogates carry ten payload bits each
                        cp = 21'h10000 + {high_sur[9:0], hex_acc[9:0]};
                        utf8_bytes.push_back({5'b11110, cp[20:18]});
                        utf8_bytes.push_back({2'b10, cp[17:12]});
                        utf8_bytes.push_back({2'b10, cp[11:6]});
                        utf8_bytes.push_back({2'b10, cp[5:0]});
                        scan = SCAN_BODY;
                    end
                    else
                    begin
                        put_bmp(high_sur);
                        settle_code(hex_acc);
                    end
                end
            end
            default:
            begin
                scan = SCAN_BODY;
                body_byte(c);
            end
        endcase

        if (end_status == ST_RUNNING && eot)
        begin
            case (scan)
                SCAN_ESC: end_status = ST_BAD_ESCAPE;
                SCAN_HEX: end_status = ST_BAD_UNICODE;
                SCAN_HIGH:
                begin
                    put_bmp(high_sur);
                    end_status = ST_UNTERMINATED;
                end
                SCAN_HIGH_BS:
                begin
                    put_bmp(high_sur);
                    end_status = ST_BAD_ESCAPE;
                end
                SCAN_LOW_HEX:
                begin
                    put_bmp(high_sur);
                    end_status = ST_BAD_UNICODE;
                end
                default: end_status = ST_UNTERMINATED;
            endcase
        end

        if (utf8_bytes.size() == 0 && end_status != ST_RUNNING)
        begin
            w = '{out_byte: 8'h00, has_byte: 1'b0, status: end_status, last: 1'b1};
            due_words.push_back(w);
        end
        for (int k = 0; k < utf8_bytes.size(); k++)
        begin
            w.out_byte = utf8_bytes[k];
            w.has_byte = 1'b1;
            w.last     = (k == utf8_bytes.size() - 1);
            w.status   = w.last ? end_status : ST_RUNNING;
            due_words.push_back(w);
        end
        if (end_status != ST_RUNNING)
            reset_scan();
    endtask

    task automatic cmp_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            n_bad++;
            $display("%0t: decoded %s mismatch: expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic check_word();
        utf8_word_t want;
        n_out++;
        if (due_words.size() == 0)
        begin
            n_bad++;
            $display("%0t: decoded word with none due: expected nothing, got %02h/%b/%0d/%b",
                     $time, decoded.out_byte, decoded.has_byte, decoded.status, decoded.last);
        end
        else
        begin
            want = due_words.pop_front();
            cmp_field("out_byte", want.out_byte, decoded.out_byte);
            cmp_field("has_byte", {7'b0, want.has_byte}, {7'b0, decoded.has_byte});
            cmp_field("status", {5'b0, want.status}, {5'b0, decoded.status});
            cmp_field("last", {7'b0, want.last}, {7'b0, decoded.last});
            if (want.status == ST_DONE)
                n_closed++;
            else if (want.status != ST_RUNNING)
                n_broken++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_scan();
            due_words.delete();
            n_bad = 0;
            n_in = 0;
            n_out = 0;
            n_closed = 0;
            n_broken = 0;
            mismatches <= 0;
            words_due <= 0;
            words_in <= 0;
            words_out <= 0;
            closed_strings <= 0;
            broken_strings <= 0;
        end
        else
        begin
            // a text word is decoded before any result of the same edge is checked
            if (text.valid && text.ready)
            begin
                n_in++;
                decode_text_word(text.text_byte, text.end_of_text);
            end
            if (decoded.valid && decoded.ready)
                check_word();
            mismatches <= n_bad;
            words_due <= due_words.size();
            words_in <= n_in;
            words_out <= n_out;
            closed_strings <= n_closed;
            broken_strings <= n_broken;
        end
    end

endmodule

>>> tb/json_string_unescape_utf8_unit_tb.sv
// testbench top: clock, reset, text stimulus, output stalls, watchdog and verdict
module json_string_unescape_utf8_unit_tb;

    localparam int RANDOM_WORDS = 370;
    localparam int PAUSE_EVERY  = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;

    logic clk;
    logic rst_n;

    jsu_in_if  text_ch();
    jsu_out_if decoded_ch();

    int mismatches, words_due, words_in, words_out, closed_strings, broken_strings;

    int         burst_left;
    int         words_sent;
    int         quiet_cycles;
    logic [8:0] token_q[$];

    json_string_unescape_utf8_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .decoded(decoded_ch)
    );

    jsu_decode_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .text          (text_ch),
        .decoded       (decoded_ch),
        .mismatches    (mismatches),
        .words_due     (words_due),
        .words_in      (words_in),
        .words_out     (words_out),
        .closed_strings(closed_strings),
        .broken_strings(broken_strings)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] esc_letter();
        logic [7:0] letters [8];
        letters = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
        return letters[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] odd_letter();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
        return c;
    endfunction

    function automatic logic [15:0] bmp_code();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 'h7F));
            1: v = 16'($urandom_range('h80, 'h7FF));
            2: v = 16'($urandom_range('h800, 'hD7FF));
            default: v = 16'($urandom_range('hE000, 'hFFFF));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] high_code();
        return 16'($urandom_range('hD800, 'hDBFF));
    endfunction

    function automatic logic [15:0] low_code();
        return 16'($urandom_range('hDC00, 'hDFFF));
    endfunction

    task automatic put_char(input logic [7:0] c);
        token_q.push_back({1'b0, c});
    endtask

    // backslash u and four hex digits in mixed case
    task automatic put_uesc(input logic [15:0] v);
        logic [3:0] n;
        put_char("\\");
        put_char("u");
        for (int i = 3; i >= 0; i--)
        begin
            n = v[i*4 +: 4];
            if (n < 4'd10)
                put_char("0" + n);
            else
                put_char(($urandom_range(0, 1) ? "a" : "A") + n - 8'd10);
        end
    endtask

    task automatic gen_token(input int kind);
        logic [7:0] c;
        int         n;
        case (kind)
            0, 1:
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == "\"" || c == "\\");
                    put_char(c);
                end
            end
            2:
            begin
                put_char("\\");
                put_char(esc_letter());
            end
            3:
            begin
                put_char("\\");
                put_char(odd_letter());
            end
            4: put_uesc(bmp_code());
            5:
            begin
                put_uesc(high_code());
                put_uesc(low_code());
            end
            6:
            begin
                put_uesc(high_code());
                do
                    c = 8'($urandom_range(0, 255));
                while (c == "\\");
                put_char(c);
            end
            7:
            begin
                put_uesc(high_code());
                put_char("\\");
                put_char($urandom_range(0, 1) ? esc_letter() : odd_letter());
            end
            8:
            begin
                put_uesc(high_code());
                put_uesc($urandom_range(0, 1) ? high_code() : bmp_code());
            end
            9: put_uesc(low_code());
            10:
            begin
                // one of the four digits is not hex
                put_uesc(16'($urandom));
                n = $urandom_range(1, 4);
                do
                    c = 8'($urandom_range(0, 255));
                while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
                token_q[token_q.size() - n] = {1'b0, c};
            end
            11: put_char("\"");
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    token_q.push_back({($urandom_range(0, 7) == 0), 8'($urandom)});
            end
        endcase
    endtask

    task automatic send_word(input logic [7:0] c, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= c;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic flush_tokens();
        logic [8:0] w;
        while (token_q.size() != 0)
        begin
            w = token_q.pop_front();
            send_word(w[7:0], w[8]);
        end
    endtask

    // hold the text side until every decoded word has come back
    task automatic drain();
        text_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        string opening;
        int    cut;
        int    target;
        int    next_pause;
        rst_n <= 1'b0;
        text_ch.valid <= 1'b0;
        text_ch.text_byte <= 8'h00;
        text_ch.end_of_text <= 1'b0;
        burst_left = 0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // byte extremes, end of text in the body, then escapes, a surrogate pair, a quote and an unknown escape
        put_char(8'h00);
        token_q.push_back({1'b1, 8'hFF});
        opening = "\\n\\uD83d\\uDE00\\u00e9\"\\q";
        for (int i = 0; i < opening.len(); i++)
            put_char(opening[i]);
        flush_tokens();
        drain();

        target = words_sent + RANDOM_WORDS;
        next_pause = words_sent + PAUSE_EVERY;
        while (words_sent < target)
        begin
            gen_token($urandom_range(0, 12));
            // sometimes cut the sequence short and end the text there
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, token_q.size());
                while (token_q.size() > cut)
                    void'(token_q.pop_back());
                token_q[cut - 1][8] = 1'b1;
            end
            flush_tokens();
            if (words_sent >= next_pause)
            begin
                drain();
                next_pause += PAUSE_EVERY;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d text words and %0d decoded words", words_in, words_out);
        $display("%0d strings closed by a quote, %0d ended by end of text or a bad escape",
                 closed_strings, broken_strings);
        if (mismatches == 0 && words_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // output stalls: the ready pattern switches between random modes
    initial
    begin
        int   mode;
        int   span;
        int   stall_run;
        logic take;
        decoded_ch.ready <= 1'b0;
        span = 0;
        stall_run = 0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
            end
            span--;
            case (mode)
                0: take = 1'b1;
                1: take = ($urandom_range(0, 3) != 0);
                2: take = ($urandom_range(0, 3) == 0);
                default: take = ((span % 8) < 3);
            endcase
            if (stall_run >= 12)
                take = 1'b1;
            stall_run = take ? 0 : stall_run + 1;
            decoded_ch.ready <= take;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) ||
            (decoded_ch.valid && decoded_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

>>> files.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_unit.sv
tb/jsu_decode_checker.sv
tb/json_string_unescape_utf8_unit_tb.sv
